/* hdl/aws_pkg.sv */
// aws_pkg: shared constants, types and curve tables for the five-curve waveshaper.
// Standalone; used by every module under hdl/.
`default_nettype none
package aws_pkg;

   // curve table size
   localparam int CURVE_TABLE_BITS = 10;
   localparam int ROM_N            = 1 << CURVE_TABLE_BITS;
   localparam int ROM_ADDR_BITS    = CURVE_TABLE_BITS + 1;
   localparam int TANH_FRAC_BITS   = 22 - CURVE_TABLE_BITS;
   localparam int SINE_FRAC_BITS   = 30 - CURVE_TABLE_BITS;

   // curve pipeline shape
   localparam int CURVE_STAGES = 14;
   localparam int CHAIN_STAGES = 12;
   localparam int FAST_DELAY   = 9;

   // register indexes
   localparam logic [1:0] CSR_MODE        = 2'd0;
   localparam logic [1:0] CSR_INPUT_GAIN  = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_GAIN = 2'd2;
   localparam logic [1:0] CSR_DC_OFFSET   = 2'd3;

   localparam logic [16:0] GAIN_UNITY = 17'd65536;

   typedef enum logic [2:0] {
      MODE_CLAMP = 3'd0,
      MODE_TANH  = 3'd1,
      MODE_SINE  = 3'd2,
      MODE_CUBIC = 3'd3,
      MODE_ASYM  = 3'd4
   } aws_mode_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [16:0]        input_gain;
      logic [16:0]        output_gain;
      logic signed [22:0] dc_offset;
   } aws_cfg_type;

   // travels beside each word in the pipeline
   typedef struct packed {
      logic valid;
      logic block_end;
   } aws_tag_type;

   typedef logic [22:0] aws_rom_type [0:ROM_N];

   localparam longint Q30_ONE     = 64'sd1 << 30;
   localparam longint INV_E_Q30   = 64'sd395007542;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   // shift-and-subtract quotient of two non-negative values, table building only
   function automatic longint udiv(longint n, longint d);
      longint q;
      longint r;
      q = 0;
      r = 0;
      for (int i = 62; i >= 0; i--) begin
         r = (r << 1) | ((n >>> i) & 64'sd1);
         if (r >= d) begin
            r = r - d;
            q = q | (64'sd1 << i);
         end
      end
      return q;
   endfunction

   // exp(-t) in Q30, t in Q30 between 0 and 16
   function automatic longint exp_neg_q30(longint t);
      longint n;
      longint f;
      longint term;
      longint sum;
      n    = t >>> 30;
      f    = t & (Q30_ONE - 1);
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int k = 1; k <= 13; k++) begin
         term = udiv((term * f) >>> 30, longint'(k));
         if ((k & 1) == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      for (longint j = 0; j < n; j++) begin
         sum = (sum * INV_E_Q30) >>> 30;
      end
      return sum;
   endfunction

   function automatic aws_rom_type build_tanh_rom();
      aws_rom_type rom;
      longint      e;
      longint      r;
      for (int i = 0; i <= ROM_N; i++) begin
         e = exp_neg_q30(longint'(i) << (34 - CURVE_TABLE_BITS));
         r = udiv(((Q30_ONE - e) << 22) + ((Q30_ONE + e) >>> 1), Q30_ONE + e);
         rom[i] = r[22:0];
      end
      return rom;
   endfunction

   // quarter-wave sine by Taylor series
   function automatic aws_rom_type build_sine_rom();
      aws_rom_type rom;
      longint      x;
      longint      term;
      longint      sum;
      longint      r;
      for (int i = 0; i <= ROM_N; i++) begin
         x    = (HALF_PI_Q30 * longint'(i)) >>> CURVE_TABLE_BITS;
         term = x;
         sum  = x;
         for (int k = 1; k <= 8; k++) begin
            term = udiv((((term * x) >>> 30) * x) >>> 30,
                        longint'((2 * k) * (2 * k + 1)));
            if ((k & 1) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum + 128) >>> 8;
         if (r > (64'sd1 << 22)) begin
            r = 64'sd1 << 22;
         end
         rom[i] = r[22:0];
      end
      return rom;
   endfunction

   localparam aws_rom_type TANH_ROM = build_tanh_rom();
   localparam aws_rom_type SINE_ROM = build_sine_rom();

endpackage
`default_nettype wire

/* hdl/audio_waveshaper_five_curve.sv */
// Five-curve waveshaper: a Q4.19 sample in, a saturated Q1.22 sample out,
// one sample per clock unless the result channel stalls. Offset and drive gain,
// the curves (the asymmetric curve's twelve-stage power chain sets their depth)
// and output gain with saturation are registered in turn. A stall on the result
// channel freezes the whole pipeline and is passed straight back as req_stall.
// Write the registers only while no sample is in flight.
`default_nettype none
module audio_waveshaper_five_curve (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [22:0] req_sample_in,
   input  wire logic               req_block_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [22:0]      rsp_sample_out,
   output logic                    rsp_block_end_out,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_index,
   input  wire logic [22:0]        csr_wdata
);

   aws_pkg::aws_cfg_type cfg_ff;
   aws_pkg::aws_tag_type front_tag, curve_tag;
   logic signed [23:0]   v;
   logic signed [23:0]   y;
   logic                 en;

   // whole pipeline advances unless the result word is held
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= aws_pkg::MODE_TANH;
         cfg_ff.input_gain  <= aws_pkg::GAIN_UNITY;
         cfg_ff.output_gain <= aws_pkg::GAIN_UNITY;
         cfg_ff.dc_offset   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            aws_pkg::CSR_MODE:        cfg_ff.mode        <= csr_wdata[2:0];
            aws_pkg::CSR_INPUT_GAIN:  cfg_ff.input_gain  <= csr_wdata[16:0];
            aws_pkg::CSR_OUTPUT_GAIN: cfg_ff.output_gain <= csr_wdata[16:0];
            aws_pkg::CSR_DC_OFFSET:   cfg_ff.dc_offset   <= $signed(csr_wdata);
            default:                  cfg_ff.mode        <= cfg_ff.mode;
         endcase
      end
   end

   aws_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_sample_in (req_sample_in),
      .req_block_end (req_block_end),
      .tag_out       (front_tag),
      .v_out         (v)
   );

   aws_curve u_curve (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cfg     (cfg_ff),
      .tag_in  (front_tag),
      .v       (v),
      .tag_out (curve_tag),
      .y_out   (y)
   );

   aws_out u_out (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .cfg               (cfg_ff),
      .tag_in            (curve_tag),
      .y                 (y),
      .rsp_valid         (rsp_valid),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_block_end_out (rsp_block_end_out)
   );

endmodule
`default_nettype wire

/* hdl/aws_front.sv */
// aws_front: DC offset and input gain, two register stages.
// Depends on aws_pkg.
`default_nettype none
module aws_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire aws_pkg::aws_cfg_type cfg,
   input  wire logic                req_valid,
   input  wire logic signed [22:0]  req_sample_in,
   input  wire logic                req_block_end,
   output aws_pkg::aws_tag_type      tag_out,
   output logic signed [23:0]        v_out
);

   aws_pkg::aws_tag_type tag1_ff, tag2_ff;
   logic signed [22:0]   s_half;
   logic signed [23:0]   x_in, x_ff;
   logic [16:0]          gi;
   logic signed [41:0]   prod;
   logic signed [23:0]   v_in, v_ff;

   // offset, with the sample halved in the asymmetric curve
   always_comb begin
      s_half = (cfg.mode == aws_pkg::MODE_ASYM) ? (req_sample_in >>> 1) : req_sample_in;
      x_in   = 24'(s_half) + 24'(cfg.dc_offset);
   end

   // drive gain, capped at unity
   always_comb begin
      gi   = (cfg.input_gain > aws_pkg::GAIN_UNITY) ? aws_pkg::GAIN_UNITY : cfg.input_gain;
      prod = x_ff * $signed({1'b0, gi});
      v_in = prod[39:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else if (en) begin
         tag1_ff <= '{valid: req_valid, block_end: req_block_end};
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         v_ff <= v_in;
      end
   end

   assign tag_out = tag2_ff;
   assign v_out   = v_ff;

endmodule
`default_nettype wire

/* hdl/aws_curve.sv */
// aws_curve: the five shaping curves, fourteen register stages.
// Depends on aws_pkg (tables, mode codes, tag type).
`default_nettype none
module aws_curve (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire aws_pkg::aws_cfg_type  cfg,
   input  wire aws_pkg::aws_tag_type  tag_in,
   input  wire logic signed [23:0]   v,
   output aws_pkg::aws_tag_type       tag_out,
   output logic signed [23:0]         y_out
);

   localparam int TFB = aws_pkg::TANH_FRAC_BITS;
   localparam int SFB = aws_pkg::SINE_FRAC_BITS;
   localparam int AB  = aws_pkg::ROM_ADDR_BITS;
   localparam int TB  = aws_pkg::CURVE_TABLE_BITS;

   typedef struct packed {
      logic [30:0]        p;
      logic [29:0]        b;
      logic [18:0]        w;
      logic               hi;
      logic               mid;
      logic               lo;
      logic signed [23:0] yq;
   } aws_chain_type;

   aws_pkg::aws_tag_type tag_ff [0:aws_pkg::CURVE_STAGES-1];

   // stage 1
   logic signed [20:0] vc_in, vc_ff;
   logic               over_in, over_ff, under_in, under_ff;
   logic signed [41:0] vsq_full;
   logic [38:0]        vsq_ff;
   logic [23:0]        va;
   logic               tsat_ff, tneg_ff;
   logic [TB-1:0]      tidx_ff;
   logic [TFB-1:0]     tfrac_ff;
   logic signed [54:0] ph_full;
   logic [31:0]        phase_ff;
   logic               hi_ff, mid_ff, lo_ff;
   logic signed [21:0] wfull;
   logic [18:0]        w_in, w_ff;
   logic [19:0]        bd;
   logic [29:0]        b_in, b_ff;

   // stage 2
   logic [19:0]        vabs;
   logic [58:0]        v3;
   logic [22:0]        n_ff;
   logic signed [20:0] vc2_ff;
   logic               over2_ff, under2_ff;
   logic [22:0]        t0_ff, t1_ff;
   logic [AB-1:0]      tidx1;
   logic [TFB-1:0]     tfrac2_ff;
   logic               tsat2_ff, tneg2_ff;
   logic [30:0]        pp;
   logic [AB-1:0]      sidx_ff;
   logic [SFB-1:0]     sfrac_ff;
   logic               sneg_ff;
   logic signed [63:0] qt;
   aws_chain_type      ch0_in;
   aws_chain_type      ch_ff [0:aws_pkg::CHAIN_STAGES-1];

   // stage 3
   logic signed [23:0]         tdiff;
   logic signed [24+TFB:0]     tprod;
   logic signed [24+TFB:0]     tsh;
   logic signed [24:0]         tm, tmm, y1;
   logic [46:0]                qprod;
   logic [21:0]                q3;
   logic signed [24:0]         qs, vc8, y3;
   logic signed [23:0]         y013_in, y013_ff;
   logic [AB-1:0]              sidx1;
   logic [22:0]                s0_ff, s1_ff;
   logic [SFB-1:0]             sfrac3_ff;
   logic                       sneg3_ff;

   // stage 4
   logic signed [23:0]         sdiff;
   logic signed [24+SFB:0]     sprod;
   logic signed [24+SFB:0]     ssh;
   logic signed [24:0]         sm, y2;
   logic signed [23:0]         yfast_in, yfast_ff;
   logic signed [23:0]         ydl_ff [0:aws_pkg::FAST_DELAY-1];

   // stage 14
   aws_chain_type              cl;
   logic [33:0]                wm;
   logic [32:0]                inner;
   logic [34:0]                t3;
   logic signed [26:0]         ya;
   logic signed [23:0]         asym, y_in, y_ff;

   // one step of the b^12 product, Q30
   function automatic aws_chain_type chain_step(aws_chain_type c);
      aws_chain_type r;
      logic [60:0]   pm;
      pm   = c.p * c.b;
      r    = c;
      r.p  = pm[60:30];
      return r;
   endfunction

   // stage 1: clamp, squares, table address, phase, asymmetric region
   always_comb begin
      over_in  = v > 24'sd524288;
      under_in = v < -24'sd524288;
      if (over_in) begin
         vc_in = 21'sd524288;
      end else if (under_in) begin
         vc_in = -21'sd524288;
      end else begin
         vc_in = v[20:0];
      end
      vsq_full = vc_in * vc_in;
      va       = v[23] ? 24'(-v) : 24'(v);
      ph_full  = v * 31'sd683565276;
      wfull    = -22'(vc_in) - 22'sd17221;
      w_in     = wfull[18:0];
      bd       = 20'd524288 - {1'b0, w_in};
      b_in     = {bd[18:0], 11'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vc_ff    <= vc_in;
         over_ff  <= over_in;
         under_ff <= under_in;
         vsq_ff   <= vsq_full[38:0];
         tsat_ff  <= va[23] | va[22];
         tidx_ff  <= va[21:TFB];
         tfrac_ff <= va[TFB-1:0];
         tneg_ff  <= v[23];
         phase_ff <= ph_full[50:19];
         hi_ff    <= v >= 24'sd167782;
         mid_ff   <= v >= -24'sd46687;
         lo_ff    <= v >= -24'sd524288;
         w_ff     <= w_in;
         b_ff     <= b_in;
      end
   end

   // stage 2: cube, tanh read, sine fold, quadratic, start of power chain
   always_comb begin
      vabs  = vc_ff[20] ? 20'(-vc_ff) : 20'(vc_ff);
      v3    = vsq_ff * vabs;
      tidx1 = {1'b0, tidx_ff} + AB'(1);
      pp    = phase_ff[30] ? ((31'd1 << 30) - {1'b0, phase_ff[29:0]})
                           : {1'b0, phase_ff[29:0]};
      qt    = -(64'sd403247 * $signed({25'd0, vsq_ff}))
              + ((64'(vc_ff) * 64'sd63) <<< 31) + 64'sd2147483648;
      // first factor of the product is b itself
      ch0_in.p   = {1'b0, b_ff};
      ch0_in.b   = b_ff;
      ch0_in.w   = w_ff;
      ch0_in.hi  = hi_ff;
      ch0_in.mid = mid_ff;
      ch0_in.lo  = lo_ff;
      ch0_in.yq  = qt[55:32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff      <= v3[57:35];
         vc2_ff    <= vc_ff;
         over2_ff  <= over_ff;
         under2_ff <= under_ff;
         t0_ff     <= aws_pkg::TANH_ROM[{1'b0, tidx_ff}];
         t1_ff     <= aws_pkg::TANH_ROM[tidx1];
         tfrac2_ff <= tfrac_ff;
         tsat2_ff  <= tsat_ff;
         tneg2_ff  <= tneg_ff;
         sidx_ff   <= pp[30:SFB];
         sfrac_ff  <= pp[SFB-1:0];
         sneg_ff   <= phase_ff[31];
      end
   end

   // power chain, one multiply per stage after the first
   always_ff @(posedge clock) begin
      if (en) begin
         ch_ff[0] <= ch0_in;
         for (int k = 1; k < aws_pkg::CHAIN_STAGES; k++) begin
            ch_ff[k] <= chain_step(ch_ff[k-1]);
         end
      end
   end

   // stage 3: tanh interpolation, cubic divide by three, sine read
   always_comb begin
      tdiff = $signed({1'b0, t1_ff}) - $signed({1'b0, t0_ff});
      tprod = tdiff * $signed({1'b0, tfrac2_ff});
      tsh   = tprod >>> TFB;
      tm    = $signed({2'b00, t0_ff}) + tsh[24:0];
      tmm   = tsat2_ff ? $signed({2'b00, aws_pkg::TANH_ROM[aws_pkg::ROM_N]}) : tm;
      y1    = tneg2_ff ? -tmm : tmm;
      // floor(n/3) by reciprocal
      qprod = n_ff * 24'd11184811;
      q3    = qprod[46:25];
      qs    = $signed({3'b000, q3});
      vc8   = 25'(vc2_ff) <<< 3;
      if (over2_ff) begin
         y3 = 25'sd2796174;
      end else if (under2_ff) begin
         y3 = -25'sd2796174;
      end else begin
         y3 = vc8 - (vc2_ff[20] ? -qs : qs);
      end
      unique case (cfg.mode)
         aws_pkg::MODE_TANH:  y013_in = y1[23:0];
         aws_pkg::MODE_CUBIC: y013_in = y3[23:0];
         default:             y013_in = vc8[23:0];
      endcase
      sidx1 = (sidx_ff == AB'(aws_pkg::ROM_N)) ? sidx_ff : sidx_ff + AB'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y013_ff   <= y013_in;
         s0_ff     <= aws_pkg::SINE_ROM[sidx_ff];
         s1_ff     <= aws_pkg::SINE_ROM[sidx1];
         sfrac3_ff <= sfrac_ff;
         sneg3_ff  <= sneg_ff;
      end
   end

   // stage 4: sine interpolation and selection of the short curves
   always_comb begin
      sdiff    = $signed({1'b0, s1_ff}) - $signed({1'b0, s0_ff});
      sprod    = sdiff * $signed({1'b0, sfrac3_ff});
      ssh      = sprod >>> SFB;
      sm       = $signed({2'b00, s0_ff}) + ssh[24:0];
      y2       = sneg3_ff ? -sm : sm;
      yfast_in = (cfg.mode == aws_pkg::MODE_SINE) ? y2[23:0] : y013_ff;
   end

   // short curves wait for the power chain
   always_ff @(posedge clock) begin
      if (en) begin
         yfast_ff <= yfast_in;
         ydl_ff[0] <= yfast_ff;
         for (int k = 1; k < aws_pkg::FAST_DELAY; k++) begin
            ydl_ff[k] <= ydl_ff[k-1];
         end
      end
   end

   // stage 14: asymmetric tail and final selection
   always_comb begin
      cl    = ch_ff[aws_pkg::CHAIN_STAGES-1];
      wm    = cl.w * 15'd21823;
      inner = (33'd1 << 30) - {2'b00, cl.p} + {4'd0, wm[33:5]};
      t3    = ({2'b00, inner} * 35'd3) + 35'd512;
      ya    = 27'sd41943 - $signed({2'b00, t3[34:10]});
      if (cl.hi) begin
         asym = 24'sd2642558;
      end else if (cl.mid) begin
         asym = cl.yq;
      end else if (cl.lo) begin
         asym = ya[23:0];
      end else begin
         asym = -24'sd4117968;
      end
      y_in = (cfg.mode == aws_pkg::MODE_ASYM) ? asym : ydl_ff[aws_pkg::FAST_DELAY-1];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < aws_pkg::CURVE_STAGES; k++) begin
            tag_ff[k] <= '0;
         end
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int k = 1; k < aws_pkg::CURVE_STAGES; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign tag_out = tag_ff[aws_pkg::CURVE_STAGES-1];
   assign y_out   = y_ff;

endmodule
`default_nettype wire

/* hdl/aws_out.sv */
// aws_out: output gain, saturation and the result register.
// Depends on aws_pkg.
`default_nettype none
module aws_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire aws_pkg::aws_cfg_type  cfg,
   input  wire aws_pkg::aws_tag_type  tag_in,
   input  wire logic signed [23:0]   y,
   output logic                      rsp_valid,
   output logic signed [22:0]        rsp_sample_out,
   output logic                      rsp_block_end_out
);

   logic [16:0]        go;
   logic signed [41:0] z;
   logic signed [25:0] zs;
   logic signed [22:0] sat_in;
   logic               valid_ff;
   logic signed [22:0] sample_ff;
   logic               block_end_ff;

   // output gain, capped at unity, then saturate to Q1.22
   always_comb begin
      go = (cfg.output_gain > aws_pkg::GAIN_UNITY) ? aws_pkg::GAIN_UNITY : cfg.output_gain;
      z  = y * $signed({1'b0, go});
      zs = z[41:16];
      if (zs > 26'sd4194303) begin
         sat_in = 23'sd4194303;
      end else if (zs < -26'sd4194304) begin
         sat_in = -23'sd4194304;
      end else begin
         sat_in = zs[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= tag_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sample_ff    <= sat_in;
         block_end_ff <= tag_in.block_end;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_sample_out    = sample_ff;
   assign rsp_block_end_out = block_end_ff;

endmodule
`default_nettype wire
